FILE: src/hpc_pkg.sv
// shared constants, types and helpers for the holographic pixel composite
`timescale 1ns / 1ps

package hpc_pkg;

    localparam logic [7:0] CH_MAX     = 8'd255;
    localparam logic [5:0] BODY_A_MUL = 6'd38;
    localparam logic [6:0] RIM_MUL    = 7'd85;
    localparam logic [8:0] SPEC_MUL   = 9'd358;
    localparam logic [7:0] LUM_MUL    = 8'd200;

    typedef struct packed {
        logic [7:0]  ac;
        logic [7:0]  al;
        logic [7:0]  ar;
        logic [7:0]  au;
        logic [7:0]  ad;
        logic [7:0]  gl;
        logic [7:0]  tr;
        logic [7:0]  tg;
        logic [7:0]  tb;
        logic [31:0] bg;
    } t_pix_in;

    typedef struct packed {
        logic [8:0]  body_r;
        logic [8:0]  body_g;
        logic [8:0]  body_b;
        logic [5:0]  ba;
        logic [8:0]  mag;
        logic [8:0]  light;
        logic [24:0] spec_p_r;
        logic [24:0] spec_p_g;
        logic [24:0] spec_p_b;
        logic [31:0] bg;
        logic        empty;
    } t_front;

    typedef struct packed {
        logic [17:0] po_r;
        logic [17:0] po_g;
        logic [17:0] po_b;
        logic [14:0] pb_r;
        logic [14:0] pb_g;
        logic [14:0] pb_b;
        logic [9:0]  sum_r;
        logic [9:0]  sum_g;
        logic [9:0]  sum_b;
        logic        ba_nz;
        logic [5:0]  ba;
        logic [7:0]  rim;
        logic [8:0]  lum;
        logic [7:0]  bga;
        logic        empty;
    } t_light;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       written;
    } t_pix_out;

    function automatic logic [7:0] sat8(input logic [11:0] v);
        logic [7:0] res;
        res = (v > 12'(CH_MAX)) ? CH_MAX : v[7:0];
        return res;
    endfunction

endpackage

FILE: src/hpc_front.sv
// stages one and two: body tint, body alpha, gradient and specular products
`timescale 1ns / 1ps

module hpc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hpc_pkg::t_pix_in i_pix,
    output logic            o_up_ready,
    output logic            o_valid,
    output hpc_pkg::t_front o_front,
    input  logic            i_dn_ready
);

    typedef struct packed {
        logic [15:0]       p_r;
        logic [15:0]       p_g;
        logic [15:0]       p_b;
        logic [13:0]       v_r;
        logic [13:0]       v_g;
        logic [13:0]       v_b;
        logic [15:0]       q_r;
        logic [15:0]       q_g;
        logic [15:0]       q_b;
        logic [7:0]        amax;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic              has_body;
        logic              empty;
        logic [31:0]       bg;
    } t_s1;

    logic            r_v1, r_v2;
    t_s1             r_s1, n_s1;
    hpc_pkg::t_front r_s2, n_s2;
    logic            w_en1, w_en2;

    logic [7:0]        w_m1;
    logic [13:0]       w_bam;
    logic [8:0]        w_adx, w_ady;
    logic signed [9:0] w_sxy;
    logic [8:0]        w_light;

    assign w_en2      = ~r_v2 | i_dn_ready;
    assign w_en1      = ~r_v1 | w_en2;
    assign o_up_ready = w_en1;
    assign o_valid    = r_v2;
    assign o_front    = r_s2;

    always_comb begin
        w_m1          = (i_pix.ac > i_pix.ar) ? i_pix.ac : i_pix.ar;
        n_s1.p_r      = {8'd0, i_pix.tr} * {8'd0, i_pix.al};
        n_s1.p_g      = {8'd0, i_pix.tg} * {8'd0, i_pix.ac};
        n_s1.p_b      = {8'd0, i_pix.tb} * {8'd0, i_pix.ar};
        n_s1.v_r      = {6'd0, i_pix.tr} * {8'd0, i_pix.gl[7:2]};
        n_s1.v_g      = {6'd0, i_pix.tg} * {8'd0, i_pix.gl[7:2]};
        n_s1.v_b      = {6'd0, i_pix.tb} * {8'd0, i_pix.gl[7:2]};
        n_s1.q_r      = {8'd0, i_pix.tr} * {8'd0, i_pix.gl};
        n_s1.q_g      = {8'd0, i_pix.tg} * {8'd0, i_pix.gl};
        n_s1.q_b      = {8'd0, i_pix.tb} * {8'd0, i_pix.gl};
        n_s1.amax     = (i_pix.al > w_m1) ? i_pix.al : w_m1;
        n_s1.dx       = $signed({1'b0, i_pix.ar}) - $signed({1'b0, i_pix.al});
        n_s1.dy       = $signed({1'b0, i_pix.ad}) - $signed({1'b0, i_pix.au});
        n_s1.has_body = (i_pix.al != 8'd0) || (i_pix.ac != 8'd0) || (i_pix.ar != 8'd0);
        n_s1.empty    = !n_s1.has_body && (i_pix.gl == 8'd0);
        n_s1.bg       = i_pix.bg;
    end

    always_comb begin
        w_bam   = {6'd0, r_s1.amax} * {8'd0, hpc_pkg::BODY_A_MUL};
        w_adx   = r_s1.dx[8] ? 9'(-r_s1.dx) : r_s1.dx;
        w_ady   = r_s1.dy[8] ? 9'(-r_s1.dy) : r_s1.dy;
        w_sxy   = {r_s1.dx[8], r_s1.dx} + {r_s1.dy[8], r_s1.dy};
        w_light = w_sxy[9] ? 9'(-w_sxy) : 9'd0;

        n_s2.body_r   = {1'b0, r_s1.p_r[15:8]} + {3'b0, r_s1.v_r[13:8]};
        n_s2.body_g   = {1'b0, r_s1.p_g[15:8]} + {3'b0, r_s1.v_g[13:8]};
        n_s2.body_b   = {1'b0, r_s1.p_b[15:8]} + {3'b0, r_s1.v_b[13:8]};
        n_s2.ba       = w_bam[13:8];
        n_s2.mag      = r_s1.has_body ? 9'(w_adx + w_ady) : 9'd0;
        n_s2.light    = r_s1.has_body ? w_light : 9'd0;
        n_s2.spec_p_r = {9'd0, r_s1.q_r} * {16'd0, hpc_pkg::SPEC_MUL};
        n_s2.spec_p_g = {9'd0, r_s1.q_g} * {16'd0, hpc_pkg::SPEC_MUL};
        n_s2.spec_p_b = {9'd0, r_s1.q_b} * {16'd0, hpc_pkg::SPEC_MUL};
        n_s2.bg       = r_s1.bg;
        n_s2.empty    = r_s1.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
    end

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_en1) |=> $stable(r_s1))
        else $error("stage one beat changed while stalled");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !i_dn_ready) |=> (r_v2 && $stable(r_s2)))
        else $error("stage two beat lost or changed while stalled");

endmodule

FILE: src/hpc_light.sv
// stages three and four: specular sum, rim light, blend products and glow luminance
`timescale 1ns / 1ps

module hpc_light (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hpc_pkg::t_front i_front,
    output logic            o_up_ready,
    output logic            o_valid,
    output hpc_pkg::t_light o_light,
    input  logic            i_dn_ready
);

    typedef struct packed {
        logic [9:0] sum_r;
        logic [9:0] sum_g;
        logic [9:0] sum_b;
        logic [7:0] rim;
        logic [8:0] smax;
        logic [8:0] body_r;
        logic [8:0] body_g;
        logic [8:0] body_b;
        logic [5:0] ba;
        logic [7:0] bga;
        logic       empty;
    } t_s3;

    logic            r_v3, r_v4;
    t_s3             r_s3, n_s3;
    hpc_pkg::t_light r_s4, n_s4;
    logic            w_en3, w_en4;

    logic [8:0]  w_sp_r, w_sp_g, w_sp_b, w_sm;
    logic [15:0] w_rm;
    logic [9:0]  w_rim_pre;
    logic [7:0]  w_inv;
    logic [15:0] w_rsq;
    logic [16:0] w_lum;

    assign w_en4      = ~r_v4 | i_dn_ready;
    assign w_en3      = ~r_v3 | w_en4;
    assign o_up_ready = w_en3;
    assign o_valid    = r_v4;
    assign o_light    = r_s4;

    always_comb begin
        w_sp_r    = i_front.spec_p_r[24:16];
        w_sp_g    = i_front.spec_p_g[24:16];
        w_sp_b    = i_front.spec_p_b[24:16];
        w_sm      = (w_sp_g > w_sp_b) ? w_sp_g : w_sp_b;
        w_rm      = {7'd0, i_front.mag} * {9'd0, hpc_pkg::RIM_MUL};
        w_rim_pre = {2'b0, w_rm[15:8]} + {1'b0, i_front.light};

        n_s3.sum_r  = {2'b0, i_front.bg[23:16]} + {1'b0, w_sp_r};
        n_s3.sum_g  = {2'b0, i_front.bg[15:8]} + {1'b0, w_sp_g};
        n_s3.sum_b  = {2'b0, i_front.bg[7:0]} + {1'b0, w_sp_b};
        n_s3.rim    = hpc_pkg::sat8({2'b0, w_rim_pre});
        n_s3.smax   = (w_sp_r > w_sm) ? w_sp_r : w_sm;
        n_s3.body_r = i_front.body_r;
        n_s3.body_g = i_front.body_g;
        n_s3.body_b = i_front.body_b;
        n_s3.ba     = i_front.ba;
        n_s3.bga    = i_front.bg[31:24];
        n_s3.empty  = i_front.empty;
    end

    always_comb begin
        w_inv = hpc_pkg::CH_MAX - {2'b0, r_s3.ba};
        w_rsq = {8'd0, r_s3.rim} * {8'd0, r_s3.rim};
        w_lum = {8'd0, r_s3.smax} * {9'd0, hpc_pkg::LUM_MUL};

        n_s4.po_r  = {8'd0, r_s3.sum_r} * {10'd0, w_inv};
        n_s4.po_g  = {8'd0, r_s3.sum_g} * {10'd0, w_inv};
        n_s4.po_b  = {8'd0, r_s3.sum_b} * {10'd0, w_inv};
        n_s4.pb_r  = {6'd0, r_s3.body_r} * {9'd0, r_s3.ba};
        n_s4.pb_g  = {6'd0, r_s3.body_g} * {9'd0, r_s3.ba};
        n_s4.pb_b  = {6'd0, r_s3.body_b} * {9'd0, r_s3.ba};
        n_s4.sum_r = r_s3.sum_r;
        n_s4.sum_g = r_s3.sum_g;
        n_s4.sum_b = r_s3.sum_b;
        n_s4.ba_nz = (r_s3.ba != 6'd0);
        n_s4.ba    = r_s3.ba;
        n_s4.rim   = w_rsq[15:8];
        n_s4.lum   = w_lum[16:8];
        n_s4.bga   = r_s3.bga;
        n_s4.empty = r_s3.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en3) begin
                r_v3 <= i_valid;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3 <= n_s3;
        end
        if (w_en4) begin
            r_s4 <= n_s4;
        end
    end

    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_en3) |=> (r_v3 && $stable(r_s3)))
        else $error("stage three beat lost or changed while stalled");

endmodule

FILE: src/hpc_blend.sv
// stage five: blend, rim add, saturation, final alpha and output register
`timescale 1ns / 1ps

module hpc_blend (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hpc_pkg::t_light   i_light,
    output logic              o_up_ready,
    output logic              o_valid,
    output hpc_pkg::t_pix_out o_pix,
    input  logic              i_dn_ready
);

    logic              r_v5;
    hpc_pkg::t_pix_out r_s5, n_s5;
    logic              w_en5;

    logic [18:0] w_bs_r, w_bs_g, w_bs_b;
    logic [10:0] w_bl_r, w_bl_g, w_bl_b;
    logic [7:0]  w_m1, w_m2;

    assign w_en5      = ~r_v5 | i_dn_ready;
    assign o_up_ready = w_en5;
    assign o_valid    = r_v5;
    assign o_pix      = r_s5;

    always_comb begin
        w_bs_r = {1'b0, i_light.po_r} + {4'b0, i_light.pb_r};
        w_bs_g = {1'b0, i_light.po_g} + {4'b0, i_light.pb_g};
        w_bs_b = {1'b0, i_light.po_b} + {4'b0, i_light.pb_b};
        w_bl_r = i_light.ba_nz ? w_bs_r[18:8] : {1'b0, i_light.sum_r};
        w_bl_g = i_light.ba_nz ? w_bs_g[18:8] : {1'b0, i_light.sum_g};
        w_bl_b = i_light.ba_nz ? w_bs_b[18:8] : {1'b0, i_light.sum_b};
        w_m1   = (i_light.bga > {2'b0, i_light.ba}) ? i_light.bga : {2'b0, i_light.ba};
        w_m2   = (w_m1 > i_light.rim) ? w_m1 : i_light.rim;

        n_s5.r       = hpc_pkg::sat8({1'b0, w_bl_r} + {4'b0, i_light.rim});
        n_s5.g       = hpc_pkg::sat8({1'b0, w_bl_g} + {4'b0, i_light.rim});
        n_s5.b       = hpc_pkg::sat8({1'b0, w_bl_b} + {4'b0, i_light.rim});
        n_s5.a       = (i_light.lum > {1'b0, w_m2}) ?
                       hpc_pkg::sat8({3'b0, i_light.lum}) : w_m2;
        n_s5.written = !i_light.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en5) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_s5 <= n_s5;
        end
    end

    a_alpha_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && w_en5) |=> (r_s5.a >= $past(i_light.bga)))
        else $error("output alpha below background alpha");

endmodule

FILE: src/holographic_pixel_composite.sv
// top level of the holographic pixel composite shader
`timescale 1ns / 1ps

// one pixel per clock when the output does not stall: a beat can be accepted every cycle
// and the result leaves through five register stages (two front, two lighting, one output).
// each stage holds its beat while the next one is full, so a stall at the output
// backs up stage by stage; s_axis_tready is low only when all five stages hold a
// beat and m_axis_tready is low. empty pixels pass the background with tuser low.
module holographic_pixel_composite (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // alpha_center, alpha_left, alpha_right, alpha_up, alpha_down, glow_level,
    // tint_red, tint_green, tint_blue, background_pixel
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // result_alpha, result_red, result_green, result_blue
    output logic [31:0]   m_axis_tdata,
    // pixel_written
    output logic          m_axis_tuser
);

    hpc_pkg::t_pix_in  w_pix;
    hpc_pkg::t_front   w_front;
    hpc_pkg::t_light   w_light;
    hpc_pkg::t_pix_out w_out;
    logic              w_front_v, w_light_v;
    logic              w_light_rdy, w_blend_rdy;

    assign w_pix.ac = s_axis_tdata[7:0];
    assign w_pix.al = s_axis_tdata[15:8];
    assign w_pix.ar = s_axis_tdata[23:16];
    assign w_pix.au = s_axis_tdata[31:24];
    assign w_pix.ad = s_axis_tdata[39:32];
    assign w_pix.gl = s_axis_tdata[47:40];
    assign w_pix.tr = s_axis_tdata[55:48];
    assign w_pix.tg = s_axis_tdata[63:56];
    assign w_pix.tb = s_axis_tdata[71:64];
    assign w_pix.bg = s_axis_tdata[103:72];

    hpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_pix      (w_pix),
        .o_up_ready (s_axis_tready),
        .o_valid    (w_front_v),
        .o_front    (w_front),
        .i_dn_ready (w_light_rdy)
    );

    hpc_light u_light (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_front_v),
        .i_front    (w_front),
        .o_up_ready (w_light_rdy),
        .o_valid    (w_light_v),
        .o_light    (w_light),
        .i_dn_ready (w_blend_rdy)
    );

    hpc_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_light_v),
        .i_light    (w_light),
        .o_up_ready (w_blend_rdy),
        .o_valid    (m_axis_tvalid),
        .o_pix      (w_out),
        .i_dn_ready (m_axis_tready)
    );

    assign m_axis_tdata = {w_out.b, w_out.g, w_out.r, w_out.a};
    assign m_axis_tuser = w_out.written;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_front_v && w_light_v && m_axis_tvalid && !m_axis_tready))
        else $error("input blocked while the pipeline has room");

endmodule
